// ===== rtl/point_fuse_by_distance_macros.svh =====
// Assertion macros shared by the point fuse checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POINT_FUSE_BY_DISTANCE_MACROS_SVH
`define POINT_FUSE_BY_DISTANCE_MACROS_SVH

// Checked while reset is released.
`define PFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("point fuse assertion failed");

// Checked at every edge, reset included.
`define PFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("point fuse assertion failed");

`endif

// ===== rtl/pfd_pkg.sv =====
// Shared constants and types for the point fuse block.
// No dependencies; imported by the cell, the top level and the checker.
package pfd_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;

    // compare cells in the row; must be a power of two
    localparam int N_CELLS = 4;
    localparam int LANE_W  = $clog2(N_CELLS);

    localparam int INDEX_W   = 10;
    localparam int M_TDATA_W = ((INDEX_W + 7) / 8) * 8;

    localparam int          THR_W     = 33;
    localparam logic [32:0] THR_RESET = 33'd4295;

    // a coordinate gap of 2^17 or more can never be within threshold
    localparam int MAG_LIM_LOG = 17;
    localparam int SQ_W        = 2 * MAG_LIM_LOG;
    localparam int SUM_W       = SQ_W + 2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic flush;
    } cell_ctl_t;

endpackage

// ===== rtl/pfd_cell.sv =====
// One compare cell: a bank of stored points and a 3-stage distance test.
// Depends on pfd_pkg. Cells chain their hit flags toward the last cell.
module pfd_cell #(
    parameter int COORD_BITS = pfd_pkg::COORD_BITS_DEF,
    parameter int DEPTH      = 256,
    parameter int ADDR_W     = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pfd_pkg::cell_ctl_t        ctl,
    input  logic                      lane_valid,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [3*COORD_BITS-1:0]   query,      // x, y, z from bit 0 up
    input  logic [pfd_pkg::THR_W-1:0] threshold,
    input  logic                      hit_left,
    output logic                      hit_right,
    output logic                      first_hit
);
    import pfd_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int AW = (DW > MAG_LIM_LOG + 1) ? DW : MAG_LIM_LOG + 1;

    logic [3*COORD_BITS-1:0] mem [DEPTH];
    logic [3*COORD_BITS-1:0] rdata_reg;

    logic            v1_reg, v2_reg, v3_reg;
    logic [2:0]      far_next, far_reg;
    logic [SQ_W-1:0] sq_next [3];
    logic [SQ_W-1:0] sq_reg  [3];
    logic [SUM_W-1:0] sum;
    logic            hit_next, hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= query;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // stage 1: per-axis magnitude of the difference and its square
    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        logic [COORD_BITS-1:0] q, s;
        logic [DW-1:0]         diff, mag;
        logic [AW-1:0]         mag_ext;
        logic [MAG_LIM_LOG-1:0] m;

        assign q       = query[ax*COORD_BITS +: COORD_BITS];
        assign s       = rdata_reg[ax*COORD_BITS +: COORD_BITS];
        assign diff    = {q[COORD_BITS-1], q} - {s[COORD_BITS-1], s};
        assign mag     = diff[DW-1] ? (~diff + DW'(1)) : diff;
        assign mag_ext = AW'(mag);
        assign far_next[ax] = |mag_ext[AW-1:MAG_LIM_LOG];
        assign m       = mag_ext[MAG_LIM_LOG-1:0];
        assign sq_next[ax] = m * m;
    end

    // stage 2: sum of squares against the threshold
    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign hit_next = v2_reg && !(|far_reg) && (sum <= SUM_W'(threshold));

    always_ff @(posedge aclk) begin
        sq_reg[0] <= sq_next[0];
        sq_reg[1] <= sq_next[1];
        sq_reg[2] <= sq_next[2];
        far_reg   <= far_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.flush) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= ctl.rd_en && lane_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            hit_reg <= hit_next;
        end
    end

    // v3 marks the row slot; hit_reg already carries its valid
    assign hit_right = hit_left || (hit_reg && v3_reg);
    assign first_hit = hit_reg && v3_reg && !hit_left;

endmodule

// ===== rtl/point_fuse_by_distance.sv =====
// A request sweeps the stored points row by row (four entries per row) and stops at the first row
// with a match; a miss sweeps every filled row, and an empty table skips the sweep.
// One request at a time: the next is taken once the result has moved into the output register,
// which waits while that register is still full.
// Reset (aresetn low, synchronous): table empty, threshold 4295, no result pending.
// Entries beyond the fill count never count as matches, so the point memory needs no clearing pass.
module point_fuse_by_distance #(
    parameter int MAX_POINTS = pfd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pfd_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config: threshold_squared
    input  logic                                  cfg_wr_en,
    input  logic [pfd_pkg::THR_W-1:0]             cfg_wr_data,
    // input requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // pos_x, pos_y, pos_z, zero pad
    input  logic [0:0]                            s_tuser,  // start_set
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pfd_pkg::M_TDATA_W-1:0]         m_tdata,  // fused_index, zero pad
    output logic [1:0]                            m_tuser   // is_new, table_full
);
    import pfd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int BASE_W = $clog2(MAX_POINTS + N_CELLS);
    localparam int DEPTH  = (MAX_POINTS + N_CELLS - 1) / N_CELLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW     = 3 * COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]     query_reg;
    logic [BASE_W-1:0] base_reg, base_next;  // first entry of the next row to read
    logic [BASE_W-1:0] cnt_ext;

    // row tags alongside the cell pipeline
    logic              v1_reg, v2_reg, v3_reg;
    logic [BASE_W-1:0] b1_reg, b2_reg, b3_reg;

    logic [INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic               res_new_reg, res_new_next;
    logic               res_full_reg, res_full_next;

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_idx_reg;
    logic               m_new_reg, m_full_reg;

    logic in_req, rows_left, issue, drained, hit_any, scan_end, wr_en, out_free;
    logic [LANE_W-1:0]  hit_lane;
    logic [N_CELLS-1:0] lane_ok, first_vec;
    logic [N_CELLS:0]   hit_chain;
    cell_ctl_t          ctl [N_CELLS];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_req   = s_tvalid && s_tready;
    assign cnt_ext  = BASE_W'(cnt_reg);
    assign out_free = !m_valid_reg || m_tready;

    // sweep control
    assign rows_left = (base_reg < cnt_ext);
    assign drained   = !rows_left && !v1_reg && !v2_reg && !v3_reg;
    assign hit_any   = hit_chain[N_CELLS];
    assign scan_end  = (state_reg == ST_SCAN) && (hit_any || drained);
    assign issue     = (state_reg == ST_SCAN) && rows_left && !scan_end;
    assign wr_en     = scan_end && !hit_any && (cnt_reg < CNT_W'(MAX_POINTS));

    always_comb begin
        hit_lane = '0;
        for (int k = 0; k < N_CELLS; k++) begin
            lane_ok[k] = (base_reg + BASE_W'(k)) < cnt_ext;
            if (first_vec[k]) begin
                hit_lane = hit_lane | LANE_W'(k);
            end
        end
    end

    // row of compare cells; the new point lands in lane cnt mod N_CELLS
    assign hit_chain[0] = 1'b0;
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        assign ctl[k].rd_en = issue;
        assign ctl[k].wr_en = wr_en && (cnt_ext[LANE_W-1:0] == LANE_W'(k));
        assign ctl[k].flush = scan_end;

        pfd_cell #(
            .COORD_BITS (COORD_BITS),
            .DEPTH      (DEPTH),
            .ADDR_W     (ADDR_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[k]),
            .lane_valid (lane_ok[k]),
            .rd_addr    (base_reg[LANE_W +: ADDR_W]),
            .wr_addr    (cnt_ext[LANE_W +: ADDR_W]),
            .query      (query_reg),
            .threshold  (thr_reg),
            .hit_left   (hit_chain[k]),
            .hit_right  (hit_chain[k+1]),
            .first_hit  (first_vec[k])
        );
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    base_next  = '0;
                    state_next = ST_SCAN;
                    if (s_tuser[0]) begin
                        cnt_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    base_next = base_reg + BASE_W'(N_CELLS);
                end
                if (scan_end) begin
                    state_next = ST_HOLD;
                    priority if (hit_any) begin
                        res_idx_next  = INDEX_W'(b3_reg + BASE_W'(hit_lane));
                        res_new_next  = 1'b0;
                        res_full_next = 1'b0;
                    end else if (wr_en) begin
                        res_idx_next  = INDEX_W'(cnt_reg);
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end else begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            thr_reg   <= THR_RESET;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && !scan_end;
            v3_reg <= v2_reg && !scan_end;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        b1_reg       <= base_reg;
        b2_reg       <= b1_reg;
        b3_reg       <= b2_reg;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        if (in_req) begin
            query_reg <= s_tdata[QW-1:0];
        end
    end

    // output register: lets the next request in while a result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_HOLD && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_HOLD && out_free) begin
            m_idx_reg  <= res_idx_reg;
            m_new_reg  <= res_new_reg;
            m_full_reg <= res_full_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_idx_reg);
    assign m_tuser  = {m_full_reg, m_new_reg};

endmodule

// ===== rtl/pfd_checker.sv =====
// Port-level checks for the point fuse block, bound to the top level.
// Depends on pfd_pkg and point_fuse_by_distance_macros.svh.
`include "point_fuse_by_distance_macros.svh"

module pfd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pfd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);
    import pfd_pkg::*;

    `PFD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `PFD_ASSERT(a_flags_excl, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    `PFD_ASSERT(a_full_idx0, aclk, aresetn, m_tvalid && m_tuser[1] |-> (m_tdata == '0))
    `PFD_ASSERT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `PFD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind point_fuse_by_distance pfd_checker u_pfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/point_fuse_by_distance_test.sv =====
// Self-checking testbench for point_fuse_by_distance: stream requests in, fused indexes out.
// Uses pfd_pkg for widths and the reset threshold; needs only the RTL of the block.
`timescale 1ns / 1ps

module point_fuse_by_distance_test;

    localparam int COORD_W   = pfd_pkg::COORD_BITS_DEF;
    localparam int TABLE_LEN = pfd_pkg::MAX_POINTS_DEF;
    localparam int IDX_W     = pfd_pkg::INDEX_W;
    localparam int S_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;

    // any per-axis gap this large squares past every legal threshold
    localparam longint GAP_LIMIT = 64'sd1 << pfd_pkg::MAG_LIM_LOG;

    localparam logic [32:0] THR_NONE = 33'd0;
    localparam logic [32:0] THR_MAX  = 33'h1_0000_0000;   // threshold of exactly 1.0
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    // cluster centers stay clear of the coordinate rails so offsets never wrap
    localparam int CENTER_SPAN = 8388608 - 262144;

    localparam int RANDOM_ITEMS   = 120;
    localparam int PHASE_ITEMS    = 30;
    localparam int WATCHDOG_LIMIT = 4000;   // worst request: gap + full sweep + stall
    localparam int TAIL_CYCLES    = 300;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one point request plus the idle gap the sender waits before offering it
    typedef struct packed {
        logic [3:0] gap;
        logic       start;
        coord_t     z;
        coord_t     y;
        coord_t     x;
    } point_req_t;

    typedef struct packed {
        logic             full;
        logic             is_new;
        logic [IDX_W-1:0] idx;
    } weld_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_wr_en   = 1'b0;
    logic [32:0]            cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // pos_x, pos_y, pos_z, zero pad
    logic [0:0]             s_tuser     = '0;   // start_set
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [pfd_pkg::M_TDATA_W-1:0] m_tdata;     // fused_index, zero pad
    logic [1:0]             m_tuser;            // is_new, table_full

    point_fuse_by_distance dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow weld table: mirrors the block's stored points and fill count
    // ------------------------------------------------------------------
    coord_t      kept_x [TABLE_LEN];
    coord_t      kept_y [TABLE_LEN];
    coord_t      kept_z [TABLE_LEN];
    int          kept_count = 0;
    logic [32:0] fuse_thr   = pfd_pkg::THR_RESET;

    point_req_t   req_pending [$];   // requests not yet offered
    weld_result_t welds_due [$];     // predicted results, oldest first
    int reqs_queued  = 0;
    int reqs_taken   = 0;
    int random_items = 0;
    int fail_count   = 0;
    bit tx_steady    = 1'b0;         // sender burst mode: no gaps
    bit rx_steady    = 1'b0;         // receiver burst mode: no stalls

    // handshake flags from the last rising edge, read by the falling-edge drivers
    logic req_took = 1'b0;
    logic res_took = 1'b0;

    // squared gap on one axis, or -1 when it can never fit a threshold
    function automatic longint gap_sq(input coord_t a, input coord_t b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return (d >= GAP_LIMIT) ? -64'sd1 : d * d;
    endfunction

    function automatic bit near_stored(input point_req_t p, input int j);
        longint sx, sy, sz;
        sx = gap_sq(p.x, kept_x[j]);
        sy = gap_sq(p.y, kept_y[j]);
        sz = gap_sq(p.z, kept_z[j]);
        if (sx < 0 || sy < 0 || sz < 0)
            return 1'b0;
        return (sx + sy + sz) <= longint'({31'b0, fuse_thr});
    endfunction

    // greedy first-match weld; appends on a miss, flags full when out of room
    function automatic weld_result_t weld_point(input point_req_t p);
        weld_result_t r;
        int j;
        bit hit;
        r   = '0;
        hit = 1'b0;
        if (p.start)
            kept_count = 0;
        for (j = 0; j < kept_count && !hit; j++) begin
            if (near_stored(p, j)) begin
                r.idx = j[IDX_W-1:0];
                hit   = 1'b1;
            end
        end
        if (!hit) begin
            if (kept_count < TABLE_LEN) begin
                kept_x[kept_count] = p.x;
                kept_y[kept_count] = p.y;
                kept_z[kept_count] = p.z;
                r.idx      = kept_count[IDX_W-1:0];
                r.is_new   = 1'b1;
                kept_count = kept_count + 1;
            end else begin
                r.full = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each accepted result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        point_req_t   seen;
        weld_result_t want;
        req_took <= aresetn && s_tvalid && s_tready;
        res_took <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            // result first: it can only belong to an earlier request
            if (m_tvalid && m_tready) begin
                if (welds_due.size() == 0) begin
                    flag_failure($sformatf("result idx=%0d new=%0b full=%0b with no request open",
                                           m_tdata[IDX_W-1:0], m_tuser[0], m_tuser[1]));
                end else begin
                    want = welds_due.pop_front();
                    if (m_tdata[IDX_W-1:0] !== want.idx || m_tuser[0] !== want.is_new ||
                        m_tuser[1] !== want.full)
                        flag_failure($sformatf(
                            "exp idx=%0d new=%0b full=%0b, got idx=%0d new=%0b full=%0b",
                            want.idx, want.is_new, want.full,
                            m_tdata[IDX_W-1:0], m_tuser[0], m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready) begin
                seen       = '0;
                seen.x     = s_tdata[COORD_W-1:0];
                seen.y     = s_tdata[2*COORD_W-1:COORD_W];
                seen.z     = s_tdata[3*COORD_W-1:2*COORD_W];
                seen.start = s_tuser[0];
                welds_due.insert(welds_due.size(), weld_point(seen));
                reqs_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers queued requests, honoring each request's idle gap
    // ------------------------------------------------------------------
    int idle_cnt = 0;
    always @(negedge aclk) begin
        point_req_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            idle_cnt = 0;
        end else if (!s_tvalid || req_took) begin
            if (req_pending.size() == 0) begin
                s_tvalid <= 1'b0;
                idle_cnt = 0;
            end else if (idle_cnt < int'(req_pending[0].gap)) begin
                s_tvalid <= 1'b0;
                idle_cnt++;
            end else begin
                cur = req_pending.pop_front();
                s_tdata  <= {cur.z, cur.y, cur.x};
                s_tuser  <= cur.start;
                s_tvalid <= 1'b1;
                idle_cnt = 0;
            end
        end
    end

    // Receiver: random stall after each result, with occasional no-stall stretches
    int stall_left = 3;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (res_took) begin
                if ($urandom_range(0, 63) == 0)
                    rx_steady = !rx_steady;
                stall_left = rx_steady ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("point_fuse_by_distance verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_point(input int x, input int y, input int z, input bit start);
        point_req_t p;
        p.x     = x[COORD_W-1:0];
        p.y     = y[COORD_W-1:0];
        p.z     = z[COORD_W-1:0];
        p.start = start;
        p.gap   = tx_steady ? 4'd0 : 4'($urandom_range(0, 15));
        req_pending.insert(req_pending.size(), p);
        reqs_queued++;
    endtask

    // wait until every request is in and answered, then for the extra quiet cycles asked for
    task automatic settle(input int extra);
        while (reqs_taken != reqs_queued || welds_due.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // threshold register write; only called with the block idle
    task automatic load_threshold(input logic [32:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        fuse_thr = value;
    endtask

    function automatic logic [32:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return THR_NONE;
            1:       return THR_MAX;
            2:       return pfd_pkg::THR_RESET;
            default: return {1'b0, $urandom} >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic int pick_center();
        return int'($urandom_range(0, 2 * CENTER_SPAN)) - CENTER_SPAN;
    endfunction

    function automatic int pick_offset(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // One run: usually starts a fresh set, then points scattered around a few
    // centers at distances near the fuse radius, with some raw noise mixed in.
    task automatic queue_cluster_run();
        int cx [6];
        int cy [6];
        int cz [6];
        int radius, spread, n, k, c, i;
        radius    = int'($sqrt(real'(fuse_thr)));
        n         = $urandom_range(2, 40);
        k         = $urandom_range(1, 6);
        tx_steady = ($urandom_range(0, 3) == 0);
        for (c = 0; c < k; c++) begin
            cx[c] = pick_center();
            cy[c] = pick_center();
            cz[c] = pick_center();
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any coordinates, stray start flags
                queue_point(int'($urandom), int'($urandom), int'($urandom),
                            $urandom_range(0, 15) == 0);
            end else begin
                c      = $urandom_range(0, k - 1);
                spread = ($urandom_range(0, 3) == 0) ? radius + 2 : radius / 2 + 1;
                queue_point(cx[c] + pick_offset(spread), cy[c] + pick_offset(spread),
                            cz[c] + pick_offset(spread),
                            i == 0 && $urandom_range(0, 7) != 0);
            end
        end
        random_items += n;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int i, phase_items, last_x, last_y, last_z, fx;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset threshold (about 0.001^2): near, boundary and rail points.
        queue_point(0, 0, 0, 1'b0);                       // empty table after reset
        queue_point(0, 0, 0, 1'b0);                       // exact repeat
        queue_point(65, 0, 0, 1'b0);                      // 4225, inside
        queue_point(66, 0, 0, 1'b0);                      // 4356, outside
        queue_point(37, 37, -37, 1'b0);                   // three axes, inside
        queue_point(38, 38, 38, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        queue_point(5, 5, 5, 1'b1);                       // start flag with its point
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        settle(8);

        // Zero threshold: only exact duplicates fuse.
        load_threshold(THR_NONE);
        queue_point(-1, -1, -1, 1'b1);
        queue_point(-1, -1, -1, 1'b0);
        queue_point(-1, -1, 0, 1'b0);
        settle(8);

        // Full-scale threshold: edge of 1.0 and the never-matching large gaps.
        load_threshold(THR_MAX);
        queue_point(0, 0, 0, 1'b1);
        queue_point(65536, 0, 0, 1'b0);                   // exactly on the threshold
        queue_point(0, -65537, 0, 1'b0);
        queue_point(131072, 0, 0, 1'b0);                  // gap of 2^17
        queue_point(37837, 37837, 37837, 1'b0);           // just inside
        queue_point(37838, 37838, 37838, 1'b0);           // just outside
        settle(8);

        // Fill the whole table with distinct points, then overflow it.
        load_threshold(THR_NONE);
        tx_steady = 1'b0;
        for (i = 0; i < TABLE_LEN; i++) begin
            fx = (int'($urandom) << 10) | i;              // low bits keep points distinct
            if (i == TABLE_LEN - 1) begin
                last_x = fx;
                last_y = int'($urandom);
                last_z = int'($urandom);
                queue_point(last_x, last_y, last_z, 1'b0);
            end else begin
                queue_point(fx, int'($urandom), int'($urandom), i == 0);
            end
        end
        for (i = 0; i < 4; i++)
            queue_point(int'($urandom), int'($urandom), int'($urandom), 1'b0);
        queue_point(last_x, last_y, last_z, 1'b0);        // still fuses while full
        settle(0);                                        // hold off until all answered
        queue_point(7, 7, 7, 1'b1);                       // start empties a full table
        settle(8);

        // Random runs over a series of thresholds, the reset value and the extremes first.
        phase_items = 0;
        load_threshold(pfd_pkg::THR_RESET);
        while (random_items < RANDOM_ITEMS) begin
            queue_cluster_run();
            phase_items += 0;
            if ($urandom_range(0, 5) == 0)
                settle(0);
            if (random_items >= phase_items + PHASE_ITEMS) begin
                phase_items = random_items;
                settle(8);
                case (phase_items / PHASE_ITEMS)
                    1:       load_threshold(THR_NONE);
                    2:       load_threshold(THR_MAX);
                    default: load_threshold(pick_threshold());
                endcase
            end
        end

        settle(TAIL_CYCLES);
        if (welds_due.size() != 0)
            flag_failure($sformatf("%0d results never arrived", welds_due.size()));
        if (fail_count == 0)
            $display("point_fuse_by_distance verification clean");
        else
            $display("point_fuse_by_distance verification failed");
        $finish;
    end

endmodule
